@@ rtl/core/packed24_sample_unpacker_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packed 24-bit sample unpacker
// Clocked on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PACKED24_SAMPLE_UNPACKER_CORE_DEFINES_SVH
`define PACKED24_SAMPLE_UNPACKER_CORE_DEFINES_SVH

// same-cycle implication
`define P24U_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define P24U_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/p24u_pkg.sv @@
// ----------------------------------------------------------------------------
// p24u_pkg
// Types, constants and the channel tag function of the 24-bit unpacker.
// ----------------------------------------------------------------------------
package p24u_pkg;

    localparam int MAX_CHANNELS_DEF = 192;
    localparam int MAX_SPARE_DEF    = 16;

    localparam int WORD_W  = 32;
    localparam int CHAN_W  = 8;
    localparam int SPARE_W = 5;
    localparam int GROUP_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // result queue depth, power of two
    localparam int RESQ_DEPTH = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_GROUPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_WORDS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_MODE       = 2'd2;

    // position within a three-word group
    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    localparam logic [7:0] RUN_TAG_BASE = 8'h20;

    typedef struct packed {
        logic [15:0]        leftover;
        logic [1:0]         phase;
        logic [CHAN_W-1:0]  chan;
        logic [SPARE_W-1:0] spare;
    } state_t;

    typedef struct packed {
        logic [GROUP_W-1:0] groups;
        logic [SPARE_W-1:0] spares;
        logic               tag_mode;
    } config_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              run_last;
        logic              frame_end;
    } result_t;

    function automatic logic [7:0] make_tag(input logic tag_mode, input logic [7:0] c);
        logic [2:0] site;
        site = c[7:5] + 3'd1;
        if (tag_mode) begin
            return RUN_TAG_BASE + c;
        end
        return {c[7:5] | site, c[4:0]};
    endfunction

endpackage

@@ rtl/core/packed24_sample_unpacker_core.sv @@
// ----------------------------------------------------------------------------
// packed24_sample_unpacker_core
// Unpacks 24-bit samples (four per three words) with channel tags, then
// passes the frame's spare words.
// ----------------------------------------------------------------------------
// A new packed word can be taken every cycle while the result queue has room.
// The first and second word of each three-word group give one beat each, the
// third gives two, and the master side moves one beat a cycle, which sets the
// pace of a steady stream with the output never stalled; spare words run at
// one per cycle while the output is not stalled. The limit is the single
// output beat per cycle drained from a four-entry result queue; the slave
// side stalls only when that queue lacks room. An input beat passes the input
// register and then the result queue on its way to the output. Configuration
// writes are taken every cycle and are meant to be made while the block is
// idle.
// ----------------------------------------------------------------------------
`include "packed24_sample_unpacker_core_defines.svh"

module packed24_sample_unpacker_core #(
    parameter int MAX_CHANNELS = p24u_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SPARE    = p24u_pkg::MAX_SPARE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [p24u_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [p24u_pkg::CFG_DATA_W-1:0]  cfg_data,
    // packed word stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [p24u_pkg::WORD_W-1:0]      s_tdata,   // [31:0] packed_word
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [p24u_pkg::WORD_W-1:0]      m_tdata,   // [31:0] sample_word
    output logic                             m_tlast,   // run_last
    output logic [0:0]                       m_tuser    // [0] frame_end
);

    localparam int QCntW = $clog2(p24u_pkg::RESQ_DEPTH) + 1;

    logic                          in_vld_reg;
    logic [p24u_pkg::WORD_W-1:0]   in_word_reg;
    p24u_pkg::state_t              state_reg;
    p24u_pkg::state_t              state_next;
    p24u_pkg::config_t             cfg_reg;

    p24u_pkg::result_t             res0;
    p24u_pkg::result_t             res1;
    p24u_pkg::result_t             head;
    logic                          two;
    logic                          room;
    logic                          consume;
    logic                          pop;
    logic                          not_empty;
    logic [QCntW-1:0]              q_count;

    p24u_unpack #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SPARE    (MAX_SPARE)
    ) u_unpack (
        .word       (in_word_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .res0       (res0),
        .res1       (res1),
        .two        (two)
    );

    // room is judged on the registered fill level only
    assign room = two ? (q_count <= QCntW'(p24u_pkg::RESQ_DEPTH - 2))
                      : (q_count <= QCntW'(p24u_pkg::RESQ_DEPTH - 1));
    assign consume  = in_vld_reg && room;
    assign s_tready = !in_vld_reg || consume;
    assign pop      = not_empty && m_tready;

    p24u_resq u_resq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push0     (consume),
        .push1     (consume && two),
        .data0     (res0),
        .data1     (res1),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (q_count)
    );

    assign m_tvalid   = not_empty;
    assign m_tdata    = head.word;
    assign m_tlast    = head.run_last;
    assign m_tuser[0] = head.frame_end;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg       <= 1'b0;
            state_reg        <= '0;
            cfg_reg.groups   <= p24u_pkg::GROUP_W'(1);
            cfg_reg.spares   <= p24u_pkg::SPARE_W'(1);
            cfg_reg.tag_mode <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (consume) begin
                state_reg <= state_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    p24u_pkg::CFG_CHANNEL_GROUPS: cfg_reg.groups   <= cfg_data[2:0];
                    p24u_pkg::CFG_SPARE_WORDS:    cfg_reg.spares   <= cfg_data[4:0];
                    p24u_pkg::CFG_TAG_MODE:       cfg_reg.tag_mode <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // a held input word waits unchanged until the queue has room
    `P24U_ASSERT_NEXT(a_hold_word, in_vld_reg && !consume,
        in_vld_reg && $stable(in_word_reg), "p24u: held word lost or changed")
    // the third-word code is the last phase in use
    `P24U_ASSERT_NOW(a_phase_range, 1'b1, state_reg.phase <= p24u_pkg::PH_THIRD,
        "p24u: word phase out of range")
    // closing a frame returns the position to its start
    `P24U_ASSERT_NEXT(a_frame_restart,
        consume && ((two && res1.frame_end) || (!two && res0.frame_end)),
        state_reg.chan == '0 && state_reg.spare == '0 &&
        state_reg.phase == p24u_pkg::PH_FIRST, "p24u: frame end without restart")
    // queue never overfills
    `P24U_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= QCntW'(p24u_pkg::RESQ_DEPTH),
        "p24u: result queue overflow")

endmodule

@@ rtl/core/p24u_unpack.sv @@
// ----------------------------------------------------------------------------
// p24u_unpack
// One-word step: splits a packed word into samples or passes a spare word,
// and works out the next frame position.
// ----------------------------------------------------------------------------
module p24u_unpack #(
    parameter int MAX_CHANNELS = p24u_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SPARE    = p24u_pkg::MAX_SPARE_DEF
) (
    input  logic [p24u_pkg::WORD_W-1:0] word,
    input  p24u_pkg::state_t            state,
    input  p24u_pkg::config_t           cfg,
    output p24u_pkg::state_t            state_next,
    output p24u_pkg::result_t           res0,
    output p24u_pkg::result_t           res1,
    output logic                        two
);

    localparam logic [p24u_pkg::GROUP_W-1:0] GroupMax = p24u_pkg::GROUP_W'(MAX_CHANNELS / 32);
    localparam logic [p24u_pkg::SPARE_W-1:0] SpareMax = p24u_pkg::SPARE_W'(MAX_SPARE);

    logic [p24u_pkg::GROUP_W-1:0] groups;
    logic [p24u_pkg::CHAN_W-1:0]  nch;
    logic [p24u_pkg::SPARE_W-1:0] nsp;
    p24u_pkg::state_t             cur;
    logic [p24u_pkg::CHAN_W-1:0]  chan1;
    logic [p24u_pkg::CHAN_W-1:0]  chan2;
    logic [p24u_pkg::SPARE_W-1:0] spare1;

    always_comb begin
        groups = cfg.groups;
        if (groups == '0) begin
            groups = p24u_pkg::GROUP_W'(1);
        end
        if (groups > GroupMax) begin
            groups = GroupMax;
        end
        nch = {groups, 5'd0};
        nsp = (cfg.spares > SpareMax) ? SpareMax : cfg.spares;
    end

    always_comb begin
        cur = state;
        // position past the frame as configured: start a new frame
        if (state.chan >= nch && state.spare >= nsp) begin
            cur.phase = p24u_pkg::PH_FIRST;
            cur.chan  = '0;
            cur.spare = '0;
        end
        chan1  = cur.chan + 8'd1;
        chan2  = cur.chan + 8'd2;
        spare1 = cur.spare + 5'd1;

        state_next = cur;
        res0       = '0;
        res1       = '0;
        two        = 1'b0;

        if (cur.chan >= nch) begin
            res0.word      = word;
            res0.run_last  = 1'b1;
            res0.frame_end = (spare1 >= nsp);
            state_next.spare = spare1;
            if (spare1 >= nsp) begin
                state_next.phase = p24u_pkg::PH_FIRST;
                state_next.chan  = '0;
                state_next.spare = '0;
            end
        end else begin
            case (cur.phase)
                p24u_pkg::PH_FIRST: begin
                    res0.word = {word[23:0], p24u_pkg::make_tag(cfg.tag_mode, cur.chan)};
                    res0.run_last       = 1'b1;
                    state_next.leftover = {8'd0, word[31:24]};
                    state_next.chan     = chan1;
                    state_next.phase    = p24u_pkg::PH_SECOND;
                end
                p24u_pkg::PH_SECOND: begin
                    res0.word = {word[15:0], cur.leftover[7:0],
                                 p24u_pkg::make_tag(cfg.tag_mode, cur.chan)};
                    res0.run_last       = 1'b1;
                    state_next.leftover = word[31:16];
                    state_next.chan     = chan1;
                    state_next.phase    = p24u_pkg::PH_THIRD;
                end
                default: begin
                    two = 1'b1;
                    res0.word = {word[7:0], cur.leftover,
                                 p24u_pkg::make_tag(cfg.tag_mode, cur.chan)};
                    res1.word = {word[31:8], p24u_pkg::make_tag(cfg.tag_mode, chan1)};
                    res1.run_last       = 1'b1;
                    res1.frame_end      = (chan2 >= nch) && (nsp == '0);
                    state_next.leftover = '0;
                    state_next.phase    = p24u_pkg::PH_FIRST;
                    state_next.chan     = chan2;
                    if (res1.frame_end) begin
                        state_next.chan  = '0;
                        state_next.spare = '0;
                    end
                end
            endcase
        end
    end

endmodule

@@ rtl/core/p24u_resq.sv @@
// ----------------------------------------------------------------------------
// p24u_resq
// Small result queue: takes one or two results a cycle, gives one.
// ----------------------------------------------------------------------------
module p24u_resq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push0,
    input  logic                push1,
    input  p24u_pkg::result_t   data0,
    input  p24u_pkg::result_t   data1,
    input  logic                pop,
    output p24u_pkg::result_t   head,
    output logic                not_empty,
    output logic [$clog2(p24u_pkg::RESQ_DEPTH):0] count
);

    localparam int PtrW = $clog2(p24u_pkg::RESQ_DEPTH);

    p24u_pkg::result_t        entry_reg [p24u_pkg::RESQ_DEPTH];
    logic [PtrW-1:0]          wr_ptr_reg;
    logic [PtrW-1:0]          rd_ptr_reg;
    logic [PtrW:0]            count_reg;
    logic [PtrW:0]            count_next;
    logic [PtrW-1:0]          wr_ptr1;

    assign wr_ptr1   = wr_ptr_reg + PtrW'(1);
    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg + (PtrW + 1)'(push0) + (PtrW + 1)'(push1) - (PtrW + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            entry_reg[wr_ptr_reg] <= data0;
        end
        if (push1) begin
            entry_reg[wr_ptr1] <= data1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PtrW'(push0) + PtrW'(push1);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule
